// ===== sv/cds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, widths and constants of the concentric disk sampler.
// ----------------------------------------------------------------------------
package cds_pkg;

    localparam int IN_BITS   = 16;
    localparam int OUT_BITS  = 16;
    localparam int ANGLE_STAGES_DEF = 16;

    // offsets are IN_BITS+1 signed, magnitudes IN_BITS unsigned
    localparam int OFS_W = IN_BITS + 1;
    localparam int QB    = 32;          // quotient bits, Q.31 with room for 1.0
    localparam int REM_W = IN_BITS + 1;
    localparam int PM_W  = 31;
    localparam int CW    = 34;          // cordic datapath
    localparam int PROD_W = OFS_W + CW;
    localparam int PF_W   = PROD_W + (32 - IN_BITS);
    localparam int SH     = 62 - OUT_BITS;

    localparam logic [29:0] PI4_Q30  = 30'd843314857;
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [IN_BITS-1:0] u_first;
        logic [IN_BITS-1:0] u_second;
    } cds_in_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] disk_x;
        logic signed [OUT_BITS-1:0] disk_y;
    } cds_out_t;

    // classified item handed from front to back
    typedef struct packed {
        logic                    zero;
        logic                    xmaj;
        logic                    neg;
        logic [IN_BITS-1:0]      ar;
        logic [IN_BITS-1:0]      ao;
        logic signed [OFS_W-1:0] r;
    } cds_cls_t;

    // fields carried alongside the datapath
    typedef struct packed {
        logic                    zero;
        logic                    xmaj;
        logic signed [OFS_W-1:0] r;
    } cds_meta_t;

    function automatic logic [29:0] atan_f(input logic [4:0] k);
        logic [29:0] v;
        case (k)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            5'd24: v = 30'd63;
            5'd25: v = 30'd31;
            5'd26: v = 30'd15;
            5'd27: v = 30'd7;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/cds_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cds_front
// Accepts square points, forms the signed offsets and picks the major axis.
// ----------------------------------------------------------------------------
module cds_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cds_pkg::cds_in_t  s_data,
    output logic              cls_valid,
    input  logic              cls_ready,
    output cds_pkg::cds_cls_t cls_data
);
    import cds_pkg::*;

    logic     valid_reg, valid_next;
    cds_cls_t cls_reg, cls_next;

    logic signed [OFS_W-1:0] ox, oy;
    logic [IN_BITS-1:0]      ax, ay;
    logic                    xmaj;

    assign s_ready = !valid_reg || cls_ready;

    always_comb begin
        ox = signed'({1'b0, s_data.u_first}) - signed'(OFS_W'(1) <<< (IN_BITS - 1));
        oy = signed'({1'b0, s_data.u_second}) - signed'(OFS_W'(1) <<< (IN_BITS - 1));
        ax = ox[OFS_W-1] ? IN_BITS'(-ox) : IN_BITS'(ox);
        ay = oy[OFS_W-1] ? IN_BITS'(-oy) : IN_BITS'(oy);
        xmaj = ax > ay;
        cls_next.zero = (ox == '0) && (oy == '0);
        cls_next.xmaj = xmaj;
        cls_next.r    = xmaj ? ox : oy;
        cls_next.ar   = xmaj ? ax : ay;
        cls_next.ao   = xmaj ? ay : ax;
        cls_next.neg  = ox[OFS_W-1] != oy[OFS_W-1];
        valid_next = s_ready ? s_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            cls_reg <= cls_next;
        end
    end

    assign cls_valid = valid_reg;
    assign cls_data  = cls_reg;

endmodule

// ===== sv/cds_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cds_queue
// Short FIFO of classified transactions between front and back.
// ----------------------------------------------------------------------------
module cds_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  cds_pkg::cds_cls_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output cds_pkg::cds_cls_t pop_data
);
    import cds_pkg::*;

    cds_cls_t mem [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic wr_en, rd_en;

    assign push_ready = count_reg != Q_CNT_W'(Q_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign wr_en      = push_valid && push_ready;
    assign rd_en      = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(wr_en) - Q_CNT_W'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (wr_en) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count exceeds depth");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && !rd_en) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree when empty");

endmodule

// ===== sv/cds_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cds_back
// Ratio divider, angle scaling, CORDIC rotation and radius multiply.
// ----------------------------------------------------------------------------
module cds_back #(
    parameter int ANGLE_STAGES = cds_pkg::ANGLE_STAGES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cls_valid,
    output logic              cls_ready,
    input  cds_pkg::cds_cls_t cls_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cds_pkg::cds_out_t m_data
);
    import cds_pkg::*;

    logic en;

    // divider stages
    logic                dv_vld_reg  [0:QB-1];
    logic [REM_W-1:0]    dv_rem_reg  [0:QB-1];
    logic [QB-1:0]       dv_q_reg    [0:QB-1];
    logic [IN_BITS-1:0]  dv_ar_reg   [0:QB-1];
    logic                dv_neg_reg  [0:QB-1];
    cds_meta_t           dv_meta_reg [0:QB-1];

    // angle scaling
    logic            pm_vld_reg;
    logic [PM_W-1:0] pm_reg;
    logic            pm_neg_reg;
    cds_meta_t       pm_meta_reg;
    logic [61:0]     pm_prod;

    // rotation stages
    logic                 cr_vld_reg  [0:ANGLE_STAGES-1];
    logic signed [CW-1:0] cr_x_reg    [0:ANGLE_STAGES-1];
    logic signed [CW-1:0] cr_y_reg    [0:ANGLE_STAGES-1];
    logic signed [CW-1:0] cr_z_reg    [0:ANGLE_STAGES-1];
    cds_meta_t            cr_meta_reg [0:ANGLE_STAGES-1];

    // radius multiply
    logic                     ml_vld_reg;
    logic signed [PROD_W-1:0] ml_px_reg, ml_py_reg;
    logic                     ml_zero_reg;

    logic     m_valid_reg;
    cds_out_t m_data_reg;

    assign en        = !m_valid_reg || m_ready;
    assign cls_ready = en;

    genvar j;
    generate
        for (j = 0; j < QB; j++) begin : g_div
            logic [REM_W-1:0]   rem_in, t, rem_out;
            logic [QB-1:0]      q_in;
            logic [IN_BITS-1:0] ar_in;
            logic               vld_in, neg_in, ge;
            cds_meta_t          meta_in;
            if (j == 0) begin : g_first
                always_comb begin
                    vld_in  = cls_valid;
                    rem_in  = {1'b0, cls_data.ao};
                    q_in    = '0;
                    ar_in   = cls_data.ar;
                    neg_in  = cls_data.neg;
                    meta_in = '{zero: cls_data.zero, xmaj: cls_data.xmaj, r: cls_data.r};
                    t       = rem_in;
                end
            end else begin : g_next
                always_comb begin
                    vld_in  = dv_vld_reg[j-1];
                    rem_in  = dv_rem_reg[j-1];
                    q_in    = dv_q_reg[j-1];
                    ar_in   = dv_ar_reg[j-1];
                    neg_in  = dv_neg_reg[j-1];
                    meta_in = dv_meta_reg[j-1];
                    t       = {rem_in[REM_W-2:0], 1'b0};
                end
            end
            always_comb begin
                ge      = t >= {1'b0, ar_in};
                rem_out = ge ? t - {1'b0, ar_in} : t;
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    dv_vld_reg[j] <= 1'b0;
                end else if (en) begin
                    dv_vld_reg[j] <= vld_in;
                end
                if (en) begin
                    dv_rem_reg[j]  <= rem_out;
                    dv_q_reg[j]    <= {q_in[QB-2:0], ge};
                    dv_ar_reg[j]   <= ar_in;
                    dv_neg_reg[j]  <= neg_in;
                    dv_meta_reg[j] <= meta_in;
                end
            end
        end
    endgenerate

    assign pm_prod = 62'(dv_q_reg[QB-1]) * 62'(PI4_Q30);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pm_vld_reg <= 1'b0;
        end else if (en) begin
            pm_vld_reg <= dv_vld_reg[QB-1];
        end
        if (en) begin
            pm_reg      <= pm_prod[61:31];
            pm_neg_reg  <= dv_neg_reg[QB-1];
            pm_meta_reg <= dv_meta_reg[QB-1];
        end
    end

    genvar i;
    generate
        for (i = 0; i < ANGLE_STAGES; i++) begin : g_rot
            logic signed [CW-1:0] x_in, y_in, z_in, dx, dy, at;
            logic                 vld_in;
            cds_meta_t            meta_in;
            if (i == 0) begin : g_first
                always_comb begin
                    vld_in  = pm_vld_reg;
                    x_in    = signed'(CW'(GAIN_Q30));
                    y_in    = '0;
                    z_in    = pm_neg_reg ? -signed'(CW'(pm_reg)) : signed'(CW'(pm_reg));
                    meta_in = pm_meta_reg;
                end
            end else begin : g_next
                always_comb begin
                    vld_in  = cr_vld_reg[i-1];
                    x_in    = cr_x_reg[i-1];
                    y_in    = cr_y_reg[i-1];
                    z_in    = cr_z_reg[i-1];
                    meta_in = cr_meta_reg[i-1];
                end
            end
            always_comb begin
                dx = y_in >>> (i % 32);
                dy = x_in >>> (i % 32);
                at = signed'(CW'(atan_f(5'(i % 32))));
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    cr_vld_reg[i] <= 1'b0;
                end else if (en) begin
                    cr_vld_reg[i] <= vld_in;
                end
                if (en) begin
                    if (!z_in[CW-1]) begin
                        cr_x_reg[i] <= x_in - dx;
                        cr_y_reg[i] <= y_in + dy;
                        cr_z_reg[i] <= z_in - at;
                    end else begin
                        cr_x_reg[i] <= x_in + dx;
                        cr_y_reg[i] <= y_in - dy;
                        cr_z_reg[i] <= z_in + at;
                    end
                    cr_meta_reg[i] <= meta_in;
                end
            end
        end
    endgenerate

    logic signed [CW-1:0] rx, ry;
    cds_meta_t            lm;
    always_comb begin
        lm = cr_meta_reg[ANGLE_STAGES-1];
        rx = lm.xmaj ? cr_x_reg[ANGLE_STAGES-1] : cr_y_reg[ANGLE_STAGES-1];
        ry = lm.xmaj ? cr_y_reg[ANGLE_STAGES-1] : cr_x_reg[ANGLE_STAGES-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ml_vld_reg <= 1'b0;
        end else if (en) begin
            ml_vld_reg <= cr_vld_reg[ANGLE_STAGES-1];
        end
        if (en) begin
            ml_px_reg   <= PROD_W'(lm.r) * PROD_W'(rx);
            ml_py_reg   <= PROD_W'(lm.r) * PROD_W'(ry);
            ml_zero_reg <= lm.zero;
        end
    end

    function automatic logic signed [OUT_BITS-1:0] finish(input logic signed [PROD_W-1:0] p);
        logic signed [PF_W-1:0] pf, v, hi, lo;
        pf = PF_W'(p) <<< (32 - IN_BITS);
        v  = (pf + (PF_W'(1) <<< (SH - 1))) >>> SH;
        hi = (PF_W'(1) <<< (OUT_BITS - 1)) - PF_W'(1);
        lo = -(PF_W'(1) <<< (OUT_BITS - 1));
        if (v > hi) begin
            v = hi;
        end
        if (v < lo) begin
            v = lo;
        end
        return v[OUT_BITS-1:0];
    endfunction

    cds_out_t m_data_next;
    always_comb begin
        if (ml_zero_reg) begin
            m_data_next = '0;
        end else begin
            m_data_next.disk_x = finish(ml_px_reg);
            m_data_next.disk_y = finish(ml_py_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= ml_vld_reg;
        end
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sv/concentric_disk_sample.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// concentric_disk_sample
// Concentric square-to-disk mapping, one point per cycle when m_ready does not stall, fully pipelined.
// ----------------------------------------------------------------------------
// Pipeline from accept to result: front register, queue, 32-stage ratio
//   divider, angle multiply, ANGLE_STAGES rotation stages, radius multiply,
//   output register.
// Throughput: one transaction per cycle; the pipeline stalls only on m_ready.
// Reset: synchronous on aresetn low; clears all valid flags and the queue.
module concentric_disk_sample #(
    parameter int ANGLE_STAGES = cds_pkg::ANGLE_STAGES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cds_pkg::cds_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cds_pkg::cds_out_t m_data
);
    import cds_pkg::*;

    logic     f_valid, f_ready, b_valid, b_ready;
    cds_cls_t f_data, b_data;

    cds_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cls_valid (f_valid),
        .cls_ready (f_ready),
        .cls_data  (f_data)
    );

    cds_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    cds_back #(
        .ANGLE_STAGES (ANGLE_STAGES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cls_valid (b_valid),
        .cls_ready (b_ready),
        .cls_data  (b_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
